// ===== hw/rtl/lldp_txcs_pkg.sv =====
// shared types and constants of the lldp transmit credit scheduler
// no dependencies; imported by lldp_txcs_step and lldp_tx_credit_scheduler
`default_nettype none

package lldp_txcs_pkg;

  localparam int unsigned CreditW   = 8;
  localparam int unsigned IntervalW = 12;
  localparam int unsigned HoldW     = 7;
  localparam int unsigned JitterW   = 9;
  localparam int unsigned MsW       = 10;
  localparam int unsigned CountW    = 22;
  localparam int unsigned TtlW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;

  localparam logic [CreditW-1:0]   CreditMaxReset  = CreditW'(30);
  localparam logic [IntervalW-1:0] TxIntervalReset = IntervalW'(30);
  localparam logic [HoldW-1:0]     TxHoldReset     = HoldW'(4);
  localparam logic [MsW-1:0]       MsPerSecond     = MsW'(1000);
  localparam logic [JitterW-1:0]   JitterMax       = JitterW'(400);
  localparam logic [TtlW-1:0]      TtlMax          = TtlW'(65535);

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CREDIT_MAX  = 2'd0,
    CFG_TX_INTERVAL = 2'd1,
    CFG_TX_HOLD     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [JitterW-1:0] jitter_ms;
  } in_req_t;

  typedef struct packed {
    logic               send_now;
    logic [CreditW-1:0] credit_left;
    logic [TtlW-1:0]    advertised_ttl;
    logic               running;
  } out_rsp_t;

  typedef struct packed {
    logic [CreditW-1:0]   credit_max;
    logic [IntervalW-1:0] tx_interval;
    logic [HoldW-1:0]     tx_hold;
  } cfg_t;

  typedef struct packed {
    logic               agent_on;
    logic [CreditW-1:0] credit_count;
    logic [MsW-1:0]     ms_in_second;
    logic [CountW-1:0]  countdown_ms;
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lldp_txcs_step.sv =====
// next-state and result logic for one request of the transmit scheduler
// depends on lldp_txcs_pkg
`default_nettype none

module lldp_txcs_step (
  input  lldp_txcs_pkg::in_req_t  req_i,
  input  lldp_txcs_pkg::cfg_t     cfg_i,
  input  lldp_txcs_pkg::state_t   state_i,
  output lldp_txcs_pkg::state_t   state_o,
  output lldp_txcs_pkg::out_rsp_t rsp_o
);
  import lldp_txcs_pkg::*;

  logic [JitterW-1:0]   jitter;
  logic [CountW-1:0]    delay_interval;
  logic [CountW-1:0]    delay_one;
  logic [MsW:0]         ms_inc;
  logic [CreditW:0]     credit_inc;
  logic [CreditW-1:0]   credit_pre;
  logic                 attempt;
  logic                 send;
  logic [HoldW+IntervalW-1:0] ttl_prod;
  logic [HoldW+IntervalW:0]   ttl_sum;
  state_t               ns;

  assign jitter = (req_i.jitter_ms > JitterMax) ? JitterMax : req_i.jitter_ms;
  assign delay_interval = CountW'(cfg_i.tx_interval) * CountW'(MsPerSecond)
                        + CountW'(jitter);
  assign delay_one      = CountW'(MsPerSecond) + CountW'(jitter);

  assign ms_inc     = {1'b0, state_i.ms_in_second} + (MsW+1)'(1);
  assign credit_inc = {1'b0, state_i.credit_count} + (CreditW+1)'(1);

  always_comb begin
    ns         = state_i;
    credit_pre = state_i.credit_count;
    attempt    = 1'b0;
    unique case (kind_e'(req_i.kind))
      KIND_START: begin
        ns          = '0;
        ns.agent_on = 1'b1;
        credit_pre  = cfg_i.credit_max;
        attempt     = 1'b1;
      end
      KIND_STOP: begin
        ns         = '0;
        credit_pre = '0;
      end
      KIND_TICK: begin
        if (state_i.agent_on) begin
          ns.ms_in_second = ms_inc[MsW-1:0];
          if (ms_inc >= (MsW+1)'(MsPerSecond)) begin
            // one more credit per full second, clamped to the ceiling
            ns.ms_in_second = '0;
            credit_pre = (credit_inc > (CreditW+1)'(cfg_i.credit_max)) ?
                         cfg_i.credit_max : credit_inc[CreditW-1:0];
          end
          if (state_i.countdown_ms <= CountW'(1)) begin
            attempt = 1'b1;
          end else begin
            ns.countdown_ms = state_i.countdown_ms - CountW'(1);
          end
        end
      end
      default: begin
        ns = state_i;
      end
    endcase

    send            = attempt && (credit_pre != '0);
    ns.credit_count = send ? credit_pre - CreditW'(1) : credit_pre;
    if (attempt) begin
      ns.countdown_ms = send ? delay_interval : delay_one;
    end
  end

  assign ttl_prod = (HoldW+IntervalW)'(cfg_i.tx_hold) * (HoldW+IntervalW)'(cfg_i.tx_interval);
  assign ttl_sum  = {1'b0, ttl_prod} + (HoldW+IntervalW+1)'(1);

  assign state_o = ns;

  always_comb begin
    rsp_o.send_now       = send;
    rsp_o.credit_left    = ns.credit_count;
    rsp_o.advertised_ttl = (ttl_sum >= (HoldW+IntervalW+1)'(TtlMax)) ?
                           TtlMax : ttl_sum[TtlW-1:0];
    rsp_o.running        = ns.agent_on;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lldp_tx_credit_scheduler.sv =====
// top level of the lldp transmit credit scheduler: config registers,
// input register, scheduler state and result register; uses lldp_txcs_pkg, lldp_txcs_step
`default_nettype none

// Paces LLDP transmissions from a stream of requests: a 1 ms tick, start or
// stop. Each request yields exactly one result (send flag, credits left,
// advertised ttl, running). A request passes an input register and then one
// pass of next-state logic into the result register, and a new request is
// taken every cycle as long as results are drained; the result register
// stalls the input side only when it is full and not being taken. Config
// writes (index 0 credit_max, 1 tx_interval, 2 tx_hold, 3 ignored) are
// always accepted and belong to idle periods only.
module lldp_tx_credit_scheduler (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  lldp_txcs_pkg::in_req_t                   in_req_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output lldp_txcs_pkg::out_rsp_t                  out_rsp_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [lldp_txcs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lldp_txcs_pkg::CfgDataW-1:0]       cfg_data_i
);
  import lldp_txcs_pkg::*;

  cfg_t     cfg_q;
  logic     s1_valid_q;
  in_req_t  s1_req_q;
  state_t   state_q, state_d;
  logic     out_valid_q;
  out_rsp_t out_rsp_q, out_rsp_d;
  logic     s1_advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.credit_max  <= CreditMaxReset;
      cfg_q.tx_interval <= TxIntervalReset;
      cfg_q.tx_hold     <= TxHoldReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CREDIT_MAX:  cfg_q.credit_max  <= cfg_data_i[CreditW-1:0];
        CFG_TX_INTERVAL: cfg_q.tx_interval <= cfg_data_i[IntervalW-1:0];
        CFG_TX_HOLD:     cfg_q.tx_hold     <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 moves on when the result register is free or being drained
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_req_q <= in_req_i;
    end
  end

  lldp_txcs_step u_step (
    .req_i   (s1_req_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .rsp_o   (out_rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_advance) begin
        state_q <= state_d;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTH
  a_send_implies_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.send_now |-> out_rsp_o.running)
    else $error("send reported while agent stopped");

  a_ms_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ms_in_second < MsPerSecond)
    else $error("millisecond counter out of range");

  a_stopped_is_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.agent_on |-> (state_q.credit_count == '0) && (state_q.countdown_ms == '0)
                          && (state_q.ms_in_second == '0))
    else $error("stopped agent holds leftover state");

  a_result_follows_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> out_valid_q)
    else $error("advanced request produced no result");
`endif

endmodule

`default_nettype wire
